@@ src/gda_pkg.sv @@
package gda_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int DNUM_W  = 23;   // day number of any input date
    localparam int ACC_W   = 25;   // signed day accumulator
    localparam int LEN_W   = 18;   // widest period length (400 years)
    localparam int STEP_W  = 9;    // widest year step (400)

    // Command codes
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_SUB      = 2'd1,
        CMD_DIFF     = 2'd2,
        CMD_VALIDATE = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_FIX,
        ST_MONTH,
        ST_NEXT,
        ST_DIFF,
        ST_SHIFT,
        ST_SPLIT,
        ST_MSPLIT,
        ST_EMIT
    } t_state;

    // Period levels of the year walk
    localparam logic [1:0] LVL_400 = 2'd0;
    localparam logic [1:0] LVL_100 = 2'd1;
    localparam logic [1:0] LVL_4   = 2'd2;
    localparam logic [1:0] LVL_1   = 2'd3;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  MAX_YEAR       = 14'd9999;
    localparam logic [YEAR_W-1:0]  MIN_VALID_YEAR = 14'd1600;
    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST      = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC   = 5'd31;
    localparam logic [ACC_W-1:0]   DAYS_TO_Y10000 = 25'd3652425;
    localparam logic [COUNT_W-1:0] DIFF_MAX       = 22'd4194303;

    // Loop limits inside one 400-year cycle
    localparam logic [4:0] CENT_LAST  = 5'd3;
    localparam logic [4:0] BLOCK_LAST = 5'd24;
    localparam logic [4:0] YEAR_LAST  = 5'd3;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [COUNT_W-1:0] days;
        logic               valid;
        logic               err;
    } t_result;

    // Days in month m; codes outside 1..12 read as 31
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Force a month code into 1..12
    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] res;
        if (m == 4'd0) begin
            res = MONTH_JAN;
        end else if (m > MONTH_DEC) begin
            res = MONTH_DEC;
        end else begin
            res = m;
        end
        return res;
    endfunction

    // Years covered by one step at a level
    function automatic logic [STEP_W-1:0] year_step(input logic [1:0] lvl);
        logic [STEP_W-1:0] s;
        case (lvl)
            LVL_400: s = 9'd400;
            LVL_100: s = 9'd100;
            LVL_4:   s = 9'd4;
            default: s = 9'd1;
        endcase
        return s;
    endfunction

    // Base days of one step when counting years up to a date
    function automatic logic [LEN_W-1:0] base_days(input logic [1:0] lvl);
        logic [LEN_W-1:0] d;
        case (lvl)
            LVL_400: d = 18'd146097;
            LVL_100: d = 18'd36524;
            LVL_4:   d = 18'd1461;
            default: d = 18'd365;
        endcase
        return d;
    endfunction

    // Exact length of the next period when splitting a day number;
    // the first period of each level may carry or lose a leap day
    function automatic logic [LEN_W-1:0] period_len(input logic [1:0] lvl,
                                                    input logic first,
                                                    input logic cent0,
                                                    input logic blk0);
        logic [LEN_W-1:0] d;
        case (lvl)
            LVL_400: d = 18'd146097;
            LVL_100: d = first ? 18'd36525 : 18'd36524;
            LVL_4:   d = (first && !cent0) ? 18'd1460 : 18'd1461;
            default: d = (first && !(blk0 && !cent0)) ? 18'd366 : 18'd365;
        endcase
        return d;
    endfunction

    // Room for another period at this level
    function automatic logic split_room(input logic [1:0] lvl, input logic [4:0] k);
        logic room;
        case (lvl)
            LVL_400: room = 1'b1;
            LVL_100: room = (k < CENT_LAST);
            LVL_4:   room = (k < BLOCK_LAST);
            default: room = (k < YEAR_LAST);
        endcase
        return room;
    endfunction

endpackage

@@ src/gregorian_date_arithmetic.sv @@
// Channel  | Handshake                  | Beat carries
// ---------+----------------------------+----------------------------------------------
// input    | i_in_valid / o_in_ready    | cmd, year/month/day a and b, day_count
// output   | o_out_valid / i_out_ready  | year/month/day out, days_between, flags
//
// One beat in flight at a time; o_in_ready is high only while the sequencer idles.
// The time a beat takes follows the year walk of the shared step unit
// (400-, 100-, 4- and 1-year periods) and the walk over the months.
// A finished result waits in the output register; the next beat is taken meanwhile
// and only its final hand-off stalls on a full output register.
// Reset (synchronous, active low) returns to idle and empties the output register.
module gregorian_date_arithmetic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [13:0] i_year_a,
    input  logic [3:0]  i_month_a,
    input  logic [4:0]  i_day_a,
    input  logic [13:0] i_year_b,
    input  logic [3:0]  i_month_b,
    input  logic [4:0]  i_day_b,
    input  logic [21:0] i_day_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [13:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [21:0] o_days_between,
    output logic        o_date_valid,
    output logic        o_range_error
);

    // Control state
    gda_pkg::t_state r_state, n_state;
    logic [1:0]      r_lvl, n_lvl;
    logic [4:0]      r_k, n_k;
    logic            r_sel_b, n_sel_b;
    logic            r_out_valid, n_out_valid;

    // Beat payload
    gda_pkg::t_cmd   r_cmd, n_cmd;
    logic [13:0]     r_ya, n_ya, r_yb, n_yb;
    logic [3:0]      r_ma, n_ma, r_mb, n_mb;
    logic [4:0]      r_da, n_da, r_db, n_db;
    logic [21:0]     r_cnt, n_cnt;

    // Working registers
    logic [13:0]        r_yr, n_yr;
    logic signed [24:0] r_acc, n_acc;
    logic [2:0]         r_nz, n_nz;
    logic               r_leap, n_leap;
    logic               r_cent0, n_cent0;
    logic               r_blk0, n_blk0;
    logic [3:0]         r_mon, n_mon;
    logic [22:0]        r_dna, n_dna;
    gda_pkg::t_result   r_res, n_res, r_out, n_out;

    // Shared step unit
    logic signed [24:0] u_day_op, u_day_res;
    logic               u_day_sub;
    logic [8:0]         u_yr_op;
    logic [14:0]        u_yr_res;
    logic               u_yr_sub;

    logic               w_accept;
    logic               w_yr_take;
    logic               w_split_take;
    logic               w_msplit_take;
    logic               w_month_more;
    logic               w_under;
    logic               w_over;
    logic               w_emit_go;
    logic               w_fwd_leap;
    logic [3:0]         w_len_month;
    logic [4:0]         w_mlen;
    logic [4:0]         w_day_src;
    logic [4:0]         w_day_cl;
    logic signed [6:0]  w_fix_add;
    logic               w_ok;
    logic [24:0]        w_mag;

    assign o_in_ready = (r_state == gda_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_emit_go  = !r_out_valid || i_out_ready;

    // Month length for the day clamp or the current month of a walk
    assign w_len_month = (r_state == gda_pkg::ST_FIX) ? r_mon : r_k[3:0];
    assign w_mlen      = gda_pkg::month_len(r_leap, w_len_month);

    // Clamp the day into 1..month length
    assign w_day_src = r_sel_b ? r_db : r_da;
    assign w_day_cl  = (w_day_src == 5'd0)  ? gda_pkg::DAY_FIRST :
                       (w_day_src > w_mlen) ? w_mlen : w_day_src;

    // Day-1 plus the leap-day correction of the year walk
    assign w_fix_add = $signed({2'b0, w_day_cl}) - 7'sd1
                     + $signed({6'b0, r_nz[0]}) + $signed({6'b0, r_nz[2]})
                     - $signed({6'b0, r_nz[1]});

    // Leap year from the remainders left by the 400/100/4 walk
    assign w_fwd_leap = !r_nz[2] && (r_nz[1] || !r_nz[0]);

    // Operand select for the step unit
    always_comb begin
        u_day_op  = '0;
        u_day_sub = 1'b0;
        u_yr_op   = gda_pkg::year_step(r_lvl);
        u_yr_sub  = 1'b1;
        case (r_state)
            gda_pkg::ST_YEAR: begin
                u_day_op = $signed({7'b0, gda_pkg::base_days(r_lvl)});
            end
            gda_pkg::ST_FIX: begin
                u_day_op = {{18{w_fix_add[6]}}, w_fix_add};
            end
            gda_pkg::ST_MONTH: begin
                u_day_op = $signed({20'b0, w_mlen});
            end
            gda_pkg::ST_NEXT: begin
                if (r_cmd == gda_pkg::CMD_DIFF) begin
                    u_day_op  = $signed({2'b0, r_dna});
                    u_day_sub = 1'b1;
                end else begin
                    u_day_op  = $signed({3'b0, r_cnt});
                    u_day_sub = (r_cmd == gda_pkg::CMD_SUB);
                end
            end
            gda_pkg::ST_SHIFT: begin
                u_day_op  = $signed(gda_pkg::DAYS_TO_Y10000);
                u_day_sub = 1'b1;
            end
            gda_pkg::ST_SPLIT: begin
                u_day_op  = $signed({7'b0, gda_pkg::period_len(r_lvl, r_k == 5'd0,
                                                                r_cent0, r_blk0)});
                u_day_sub = 1'b1;
                u_yr_sub  = 1'b0;
            end
            gda_pkg::ST_MSPLIT: begin
                u_day_op  = $signed({20'b0, w_mlen});
                u_day_sub = 1'b1;
            end
            default: begin
                u_day_op = '0;
            end
        endcase
    end

    // Step unit: day accumulator and year counter move together
    assign u_day_res = u_day_sub ? (r_acc - u_day_op) : (r_acc + u_day_op);
    assign u_yr_res  = u_yr_sub ? ({1'b0, r_yr} - {6'b0, u_yr_op})
                                : ({1'b0, r_yr} + {6'b0, u_yr_op});

    assign w_yr_take     = !u_yr_res[14];
    assign w_split_take  = gda_pkg::split_room(r_lvl, r_k) && !u_day_res[24];
    assign w_msplit_take = (r_k < {1'b0, gda_pkg::MONTH_DEC}) && !u_day_res[24];
    assign w_month_more  = ({1'b0, r_mon} > r_k);
    assign w_under       = r_acc[24];
    assign w_over        = !r_acc[24] && !u_day_res[24];
    assign w_mag         = r_acc[24] ? 25'(-r_acc) : 25'(r_acc);

    // Validity of the first date
    always_comb begin
        w_ok = (r_ya > gda_pkg::MIN_VALID_YEAR) && (r_da != 5'd0) && (r_da <= w_mlen);
        if (!(r_ma inside {[gda_pkg::MONTH_JAN:gda_pkg::MONTH_DEC]})) begin
            w_ok = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gda_pkg::ST_IDLE: begin
                if (w_accept) n_state = gda_pkg::ST_YEAR;
            end
            gda_pkg::ST_YEAR: begin
                if (!w_yr_take && r_lvl == gda_pkg::LVL_1) n_state = gda_pkg::ST_FIX;
            end
            gda_pkg::ST_FIX: begin
                n_state = (r_cmd == gda_pkg::CMD_VALIDATE) ? gda_pkg::ST_EMIT
                                                           : gda_pkg::ST_MONTH;
            end
            gda_pkg::ST_MONTH: begin
                if (!w_month_more) n_state = gda_pkg::ST_NEXT;
            end
            gda_pkg::ST_NEXT: begin
                if (r_cmd == gda_pkg::CMD_DIFF) begin
                    n_state = r_sel_b ? gda_pkg::ST_DIFF : gda_pkg::ST_YEAR;
                end else begin
                    n_state = gda_pkg::ST_SHIFT;
                end
            end
            gda_pkg::ST_DIFF: begin
                n_state = gda_pkg::ST_EMIT;
            end
            gda_pkg::ST_SHIFT: begin
                n_state = (w_under || w_over) ? gda_pkg::ST_EMIT : gda_pkg::ST_SPLIT;
            end
            gda_pkg::ST_SPLIT: begin
                if (!w_split_take && r_lvl == gda_pkg::LVL_1) n_state = gda_pkg::ST_MSPLIT;
            end
            gda_pkg::ST_MSPLIT: begin
                if (!w_msplit_take) n_state = gda_pkg::ST_EMIT;
            end
            gda_pkg::ST_EMIT: begin
                if (w_emit_go) n_state = gda_pkg::ST_IDLE;
            end
            default: begin
                n_state = gda_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        n_lvl   = r_lvl;
        n_k     = r_k;
        n_sel_b = r_sel_b;
        n_cmd   = r_cmd;
        n_ya    = r_ya;
        n_yb    = r_yb;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_da    = r_da;
        n_db    = r_db;
        n_cnt   = r_cnt;
        n_yr    = r_yr;
        n_acc   = r_acc;
        n_nz    = r_nz;
        n_leap  = r_leap;
        n_cent0 = r_cent0;
        n_blk0  = r_blk0;
        n_mon   = r_mon;
        n_dna   = r_dna;
        n_res   = r_res;
        n_out   = r_out;
        // drop the held result once taken
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            gda_pkg::ST_IDLE: begin
                // capture the beat and start the year walk of the first date
                if (w_accept) begin
                    n_cmd   = gda_pkg::t_cmd'(i_cmd);
                    n_ya    = i_year_a;
                    n_ma    = i_month_a;
                    n_da    = i_day_a;
                    n_yb    = i_year_b;
                    n_mb    = i_month_b;
                    n_db    = i_day_b;
                    n_cnt   = i_day_count;
                    n_yr    = i_year_a;
                    n_mon   = gda_pkg::clamp_month(i_month_a);
                    n_acc   = '0;
                    n_lvl   = gda_pkg::LVL_400;
                    n_k     = '0;
                    n_sel_b = 1'b0;
                    n_res   = '0;
                end
            end
            gda_pkg::ST_YEAR: begin
                // count whole periods before the year, then record the remainder
                if (w_yr_take) begin
                    n_yr  = u_yr_res[13:0];
                    n_acc = u_day_res;
                end else begin
                    if (r_lvl == gda_pkg::LVL_1) begin
                        n_leap = w_fwd_leap;
                        n_k    = {4'b0, 1'b1};
                    end else begin
                        n_nz[r_lvl] = (r_yr != 14'd0);
                    end
                    n_lvl = r_lvl + 2'd1;
                end
            end
            gda_pkg::ST_FIX: begin
                if (r_cmd == gda_pkg::CMD_VALIDATE) begin
                    n_res.valid = w_ok;
                end else begin
                    n_acc = u_day_res;
                end
            end
            gda_pkg::ST_MONTH: begin
                // add the months before the date's month
                if (w_month_more) begin
                    n_acc = u_day_res;
                    n_k   = r_k + 5'd1;
                end
            end
            gda_pkg::ST_NEXT: begin
                if (r_cmd == gda_pkg::CMD_DIFF && !r_sel_b) begin
                    // hold the first day number and walk the second date
                    n_dna   = r_acc[22:0];
                    n_sel_b = 1'b1;
                    n_yr    = r_yb;
                    n_mon   = gda_pkg::clamp_month(r_mb);
                    n_acc   = '0;
                    n_lvl   = gda_pkg::LVL_400;
                    n_k     = '0;
                end else begin
                    n_acc = u_day_res;
                end
            end
            gda_pkg::ST_DIFF: begin
                n_res.days = (w_mag > {3'b0, gda_pkg::DIFF_MAX}) ? gda_pkg::DIFF_MAX
                                                                : w_mag[21:0];
            end
            gda_pkg::ST_SHIFT: begin
                if (w_under) begin
                    n_res.year  = '0;
                    n_res.month = gda_pkg::MONTH_JAN;
                    n_res.day   = gda_pkg::DAY_FIRST;
                    n_res.err   = 1'b1;
                end else if (w_over) begin
                    n_res.year  = gda_pkg::MAX_YEAR;
                    n_res.month = gda_pkg::MONTH_DEC;
                    n_res.day   = gda_pkg::DAY_LAST_DEC;
                    n_res.err   = 1'b1;
                end else begin
                    n_yr  = '0;
                    n_lvl = gda_pkg::LVL_400;
                    n_k   = '0;
                end
            end
            gda_pkg::ST_SPLIT: begin
                // peel whole periods off the day number
                if (w_split_take) begin
                    n_acc = u_day_res;
                    n_yr  = u_yr_res[13:0];
                    n_k   = r_k + 5'd1;
                end else begin
                    n_k = '0;
                    case (r_lvl)
                        gda_pkg::LVL_100: n_cent0 = (r_k == 5'd0);
                        gda_pkg::LVL_4:   n_blk0  = (r_k == 5'd0);
                        gda_pkg::LVL_1: begin
                            n_leap = (r_k == 5'd0) && !(r_blk0 && !r_cent0);
                            n_k    = {4'b0, 1'b1};
                        end
                        default: n_k = '0;
                    endcase
                    n_lvl = r_lvl + 2'd1;
                end
            end
            gda_pkg::ST_MSPLIT: begin
                // peel whole months; the remainder is the day
                if (w_msplit_take) begin
                    n_acc = u_day_res;
                    n_k   = r_k + 5'd1;
                end else begin
                    n_res.year  = r_yr;
                    n_res.month = r_k[3:0];
                    n_res.day   = r_acc[4:0] + 5'd1;
                end
            end
            gda_pkg::ST_EMIT: begin
                if (w_emit_go) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gda_pkg::ST_IDLE;
            r_lvl       <= gda_pkg::LVL_400;
            r_k         <= '0;
            r_sel_b     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_k         <= n_k;
            r_sel_b     <= n_sel_b;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ya    <= n_ya;
        r_yb    <= n_yb;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_da    <= n_da;
        r_db    <= n_db;
        r_cnt   <= n_cnt;
        r_yr    <= n_yr;
        r_acc   <= n_acc;
        r_nz    <= n_nz;
        r_leap  <= n_leap;
        r_cent0 <= n_cent0;
        r_blk0  <= n_blk0;
        r_mon   <= n_mon;
        r_dna   <= n_dna;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_year_out     = r_out.year;
    assign o_month_out    = r_out.month;
    assign o_day_out      = r_out.day;
    assign o_days_between = r_out.days;
    assign o_date_valid   = r_out.valid;
    assign o_range_error  = r_out.err;

    // The remainder being split never goes negative
    a_split_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gda_pkg::ST_SPLIT || r_state == gda_pkg::ST_MSPLIT) |-> !r_acc[24])
        else $error("split remainder negative");

    // Month walk stays within 1..12
    a_month_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gda_pkg::ST_MSPLIT) |-> (r_k >= 5'd1 && r_k <= 5'd12))
        else $error("month index out of range");

    // A range error pins the date to one end of the calendar
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |->
            (o_days_between == '0 && !o_date_valid &&
             ((o_year_out == '0 && o_month_out == gda_pkg::MONTH_JAN &&
               o_day_out == gda_pkg::DAY_FIRST) ||
              (o_year_out == gda_pkg::MAX_YEAR && o_month_out == gda_pkg::MONTH_DEC &&
               o_day_out == gda_pkg::DAY_LAST_DEC))))
        else $error("range error with bad date fields");

    // An accepted beat starts the year walk at the 400-year level
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == gda_pkg::ST_YEAR && r_lvl == gda_pkg::LVL_400 && !r_sel_b))
        else $error("walk did not start after accept");

endmodule

@@ verif/gregorian_date_arithmetic_tb.sv @@
`timescale 1ns / 100ps

module gregorian_date_arithmetic_tb;

    import gda_pkg::*;

    localparam int N_RANDOM   = 728;
    localparam int TAIL_ITEMS = 100;
    localparam int HOLD_AT    = 150;
    localparam int LONG_HOLD  = 500;
    localparam int SETTLE     = 300;

    // Calendar predictor and queue of expected result beats
    class date_checker;
        t_result pending_results[$];
        int      errors;

        static function bit leap_year(longint y);
            return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
        endfunction

        static function longint month_days(longint y, longint m);
            longint len;
            case (m)
                2:           len = leap_year(y) ? 29 : 28;
                4, 6, 9, 11: len = 30;
                default:     len = 31;
            endcase
            return len;
        endfunction

        // Days from 0000-01-01 to January 1 of year y
        static function longint days_to_year(longint y);
            return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        endfunction

        // Day index of a date after clamping month and day into range
        static function longint day_index(longint y, longint m, longint d);
            longint n;
            longint mm;
            longint dd;
            longint len;
            longint i;
            mm = m;
            dd = d;
            if (mm < MONTH_JAN) mm = MONTH_JAN;
            if (mm > MONTH_DEC) mm = MONTH_DEC;
            len = month_days(y, mm);
            if (dd < DAY_FIRST) dd = DAY_FIRST;
            if (dd > len) dd = len;
            n = days_to_year(y);
            for (i = 1; i < mm; i++) n += month_days(y, i);
            return n + dd - 1;
        endfunction

        // Turn a non-negative day index back into a date
        static function void split_day_index(longint idx, output longint y,
                                             output longint m, output longint d);
            longint n;
            longint yy;
            longint mm;
            n  = idx;
            yy = (n * 400) / 146097;
            mm = 1;
            while (yy > 0 && days_to_year(yy) > n) yy--;
            while (days_to_year(yy + 1) <= n) yy++;
            n -= days_to_year(yy);
            while (mm < MONTH_DEC && n >= month_days(yy, mm)) begin
                n -= month_days(yy, mm);
                mm++;
            end
            y = yy;
            m = mm;
            d = n + 1;
        endfunction

        function t_result predict_date_result(t_cmd cmd, longint ya, longint ma, longint da,
                                              longint yb, longint mb, longint db,
                                              longint cnt);
            t_result r;
            longint  n;
            longint  y;
            longint  m;
            longint  d;
            longint  last;
            r    = '0;
            last = days_to_year(longint'(MAX_YEAR) + 1) - 1;
            case (cmd)
                CMD_ADD, CMD_SUB: begin
                    n = day_index(ya, ma, da);
                    n = (cmd == CMD_ADD) ? n + cnt : n - cnt;
                    // Saturate at the calendar ends and flag it
                    if (n < 0) begin
                        y = 0;
                        m = MONTH_JAN;
                        d = DAY_FIRST;
                        r.err = 1'b1;
                    end else if (n > last) begin
                        y = MAX_YEAR;
                        m = MONTH_DEC;
                        d = DAY_LAST_DEC;
                        r.err = 1'b1;
                    end else begin
                        split_day_index(n, y, m, d);
                    end
                    r.year  = y[YEAR_W-1:0];
                    r.month = m[MONTH_W-1:0];
                    r.day   = d[DAY_W-1:0];
                end
                CMD_DIFF: begin
                    n = day_index(ya, ma, da) - day_index(yb, mb, db);
                    if (n < 0) n = -n;
                    if (n > longint'(DIFF_MAX)) n = DIFF_MAX;
                    r.days = n[COUNT_W-1:0];
                end
                default: begin
                    r.valid = ya > longint'(MIN_VALID_YEAR) && ma >= MONTH_JAN &&
                              ma <= MONTH_DEC && da >= DAY_FIRST &&
                              da <= month_days(ya, ma);
                end
            endcase
            return r;
        endfunction

        function void note_request(t_cmd cmd, longint ya, longint ma, longint da,
                                   longint yb, longint mb, longint db, longint cnt);
            pending_results.push_back(predict_date_result(cmd, ya, ma, da, yb, mb, db, cnt));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %0d-%0d-%0d days %0d",
                         $time, got.year, got.month, got.day, got.days);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("year_out", want.year, got.year);
            compare_field("month_out", want.month, got.month);
            compare_field("day_out", want.day, got.day);
            compare_field("days_between", want.days, got.days);
            compare_field("date_valid", want.valid, got.valid);
            compare_field("range_error", want.err, got.err);
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_cmd       = '0;
    logic [YEAR_W-1:0]  i_year_a    = '0;
    logic [MONTH_W-1:0] i_month_a   = '0;
    logic [DAY_W-1:0]   i_day_a     = '0;
    logic [YEAR_W-1:0]  i_year_b    = '0;
    logic [MONTH_W-1:0] i_month_b   = '0;
    logic [DAY_W-1:0]   i_day_b     = '0;
    logic [COUNT_W-1:0] i_day_count = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [YEAR_W-1:0]  o_year_out;
    logic [MONTH_W-1:0] o_month_out;
    logic [DAY_W-1:0]   o_day_out;
    logic [COUNT_W-1:0] o_days_between;
    logic               o_date_valid;
    logic               o_range_error;

    date_checker board;
    int          accepted_count = 0;
    bit          tail_phase     = 1'b0;

    gregorian_date_arithmetic u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_year_a       (i_year_a),
        .i_month_a      (i_month_a),
        .i_day_a        (i_day_a),
        .i_year_b       (i_year_b),
        .i_month_b      (i_month_b),
        .i_day_b        (i_day_b),
        .i_day_count    (i_day_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_year_out     (o_year_out),
        .o_month_out    (o_month_out),
        .o_day_out      (o_day_out),
        .o_days_between (o_days_between),
        .o_date_valid   (o_date_valid),
        .o_range_error  (o_range_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offer one beat, hold it until accepted, then maybe go idle for a burst
    task automatic send_req(t_cmd cmd, logic [YEAR_W-1:0] ya, logic [MONTH_W-1:0] ma,
                            logic [DAY_W-1:0] da, logic [YEAR_W-1:0] yb,
                            logic [MONTH_W-1:0] mb, logic [DAY_W-1:0] db,
                            logic [COUNT_W-1:0] cnt);
        i_cmd       <= cmd;
        i_year_a    <= ya;
        i_month_a   <= ma;
        i_day_a     <= da;
        i_year_b    <= yb;
        i_month_b   <= mb;
        i_day_b     <= db;
        i_day_count <= cnt;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(cmd, ya, ma, da, yb, mb, db, cnt);
        accepted_count++;
        if (!tail_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Mostly well-formed dates, some calendar corners, some raw field noise
    function automatic void make_date(output logic [YEAR_W-1:0] y,
                                      output logic [MONTH_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            y = $urandom_range(0, MAX_YEAR);
            m = $urandom_range(MONTH_JAN, MONTH_DEC);
            d = $urandom_range(DAY_FIRST, date_checker::month_days(y, m));
        end else if (pick == 7) begin
            case ($urandom_range(0, 7))
                0:       y = 0;
                1:       y = MIN_VALID_YEAR;
                2:       y = MIN_VALID_YEAR + 1;
                3:       y = 1900;
                4:       y = 2000;
                5:       y = MAX_YEAR;
                6:       y = MAX_YEAR + 1;
                default: y = '1;
            endcase
            m = $urandom_range(MONTH_JAN, MONTH_DEC);
            // Last day of the month or one past it
            d = date_checker::month_days(y, m) + $urandom_range(0, 1);
        end else begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
    endfunction

    function automatic logic [COUNT_W-1:0] make_count();
        logic [COUNT_W-1:0] cnt;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: cnt = $urandom_range(0, 400);
            5, 6:          cnt = $urandom_range(0, 40000);
            7:             cnt = $urandom_range(0, DAYS_TO_Y10000);
            8:             cnt = $urandom;
            default:       cnt = ($urandom_range(0, 1) == 0) ? DIFF_MAX
                                     : $urandom_range(DAYS_TO_Y10000 - 5, DAYS_TO_Y10000 + 5);
        endcase
        return cnt;
    endfunction

    task automatic send_random();
        logic [YEAR_W-1:0]  ya;
        logic [YEAR_W-1:0]  yb;
        logic [MONTH_W-1:0] ma;
        logic [MONTH_W-1:0] mb;
        logic [DAY_W-1:0]   da;
        logic [DAY_W-1:0]   db;
        make_date(ya, ma, da);
        make_date(yb, mb, db);
        send_req(t_cmd'($urandom_range(0, 3)), ya, ma, da, yb, mb, db, make_count());
    endtask

    // Sender: reset, directed corners, random beats, drain
    initial begin : stimulus
        int k;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Validity rule: year floor, leap rules, bad month and day codes
        send_req(CMD_VALIDATE, 1600, 2, 29, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 1601, 1, 1, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 2000, 2, 29, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 1900, 2, 29, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 2023, 4, 31, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 2024, 0, 10, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 2024, 13, 10, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, 2024, 5, 0, 0, 0, 0, 0);
        send_req(CMD_VALIDATE, '1, 12, 31, 0, 0, 0, 0);
        // Shifts past both calendar ends
        send_req(CMD_ADD, MAX_YEAR, 12, 31, 0, 0, 0, 1);
        send_req(CMD_SUB, 0, 1, 1, 0, 0, 0, 1);
        send_req(CMD_ADD, 0, 1, 1, 0, 0, 0, DIFF_MAX);
        send_req(CMD_SUB, MAX_YEAR, 12, 31, 0, 0, 0, DIFF_MAX);
        // Clamping of bad dates and years above the range
        send_req(CMD_ADD, 2023, 15, 31, 0, 0, 0, 0);
        send_req(CMD_ADD, 2024, 2, 31, 0, 0, 0, 0);
        send_req(CMD_SUB, '1, 0, 0, 0, 0, 0, 0);
        send_req(CMD_SUB, 10500, 6, 15, 0, 0, 0, 200000);
        // Year and leap-day rollovers
        send_req(CMD_ADD, 1999, 12, 31, 0, 0, 0, 1);
        send_req(CMD_ADD, 0, 2, 28, 0, 0, 0, 1);
        // Difference: saturation, equal dates, clamped second date
        send_req(CMD_DIFF, 0, 1, 1, '1, 15, 31, 0);
        send_req(CMD_DIFF, 2024, 3, 1, 2024, 3, 1, 0);
        send_req(CMD_DIFF, 2000, 1, 1, 2024, 0, 0, 0);
        send_req(CMD_DIFF, 1900, 3, 1, 1900, 2, 28, 0);

        for (k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - TAIL_ITEMS) tail_phase = 1'b1;
            // Pause halfway until every pending result is back
            if (k == N_RANDOM / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (board.pending_results.size() != 0) @(posedge i_clk);
            end
            send_random();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("gregorian_date_arithmetic_tb OK");
        end else begin
            $display("gregorian_date_arithmetic_tb NOT OK");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, none in the tail
    initial begin : sink
        int n;
        int k;
        bit held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && accepted_count >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                n = $urandom_range(1, 11);
                repeat (n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            n = tail_phase ? 1 : $urandom_range(1, 16);
            repeat (n) @(posedge i_clk);
        end
    end

    // Check each accepted result beat
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.year  = o_year_out;
            got.month = o_month_out;
            got.day   = o_day_out;
            got.days  = o_days_between;
            got.valid = o_date_valid;
            got.err   = o_range_error;
            board.check_result(got);
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("gregorian_date_arithmetic_tb NOT OK");
        $finish;
    end

endmodule
